// ===== rtl/tos_pkg.sv =====
// Shared types and constants for the touch orientation solver.
// No dependencies; imported by the interfaces and all solver modules.
`timescale 1ns / 1ps

package tos_pkg;

    localparam int RAW_W       = 10;
    localparam int GOAL_W      = 9;
    localparam int ORI_W       = 3;
    localparam int ERR_W       = 12;
    localparam int MOUNT_COUNT = 8;
    localparam int ERR_MAX     = 4095;

    localparam int CFG_IW = 1;
    localparam int CFG_DW = 1;
    localparam logic [CFG_IW-1:0] CFG_FLIP_X = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_FLIP_Y = 1'b1;

    typedef struct packed {
        logic flip_x;
        logic flip_y;
    } t_flips;

    typedef struct packed {
        logic [RAW_W-1:0]  first_raw_x;
        logic [RAW_W-1:0]  first_raw_y;
        logic [GOAL_W-1:0] first_goal_x;
        logic [GOAL_W-1:0] first_goal_y;
        logic [RAW_W-1:0]  second_raw_x;
        logic [RAW_W-1:0]  second_raw_y;
        logic [GOAL_W-1:0] second_goal_x;
        logic [GOAL_W-1:0] second_goal_y;
    } t_taps;

endpackage

// ===== rtl/tos_in_if.sv =====
// Input channel of the solver: valid/ready plus the two calibration taps.
// Depends on tos_pkg for field widths.
`timescale 1ns / 1ps

interface tos_in_if import tos_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  first_raw_x;
    logic [RAW_W-1:0]  first_raw_y;
    logic [GOAL_W-1:0] first_goal_x;
    logic [GOAL_W-1:0] first_goal_y;
    logic [RAW_W-1:0]  second_raw_x;
    logic [RAW_W-1:0]  second_raw_y;
    logic [GOAL_W-1:0] second_goal_x;
    logic [GOAL_W-1:0] second_goal_y;

    modport source (
        output valid, first_raw_x, first_raw_y, first_goal_x, first_goal_y,
               second_raw_x, second_raw_y, second_goal_x, second_goal_y,
        input  ready
    );
    modport sink (
        input  valid, first_raw_x, first_raw_y, first_goal_x, first_goal_y,
               second_raw_x, second_raw_y, second_goal_x, second_goal_y,
        output ready
    );
endinterface

// ===== rtl/tos_out_if.sv =====
// Result channel of the solver: valid/ready plus orientation and error.
// Depends on tos_pkg for field widths.
`timescale 1ns / 1ps

interface tos_out_if import tos_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ORI_W-1:0] best_orientation;
    logic [ERR_W-1:0] error_pixels;

    modport source (output valid, best_orientation, error_pixels, input ready);
    modport sink   (input valid, best_orientation, error_pixels, output ready);
endinterface

// ===== rtl/tos_mount_cell.sv =====
// One mounting cell: maps both taps for mounting IDX, sums the squared
// misses and updates the running best. Two pipeline stages. Uses tos_pkg.
`timescale 1ns / 1ps

module tos_mount_cell import tos_pkg::*; #(
    parameter int PANEL_SIZE = 512,
    parameter int IDX        = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_flips                         i_flips,
    input  logic                           i_vld,
    output logic                           o_rdy,
    input  t_taps                          i_taps,
    input  logic [ORI_W-1:0]               i_best,
    input  logic [2*(($clog2(PANEL_SIZE) > RAW_W) ? $clog2(PANEL_SIZE) : RAW_W)+3:0] i_total,
    output logic                           o_vld,
    input  logic                           i_rdy,
    output t_taps                          o_taps,
    output logic [ORI_W-1:0]               o_best,
    output logic [2*(($clog2(PANEL_SIZE) > RAW_W) ? $clog2(PANEL_SIZE) : RAW_W)+3:0] o_total
);

    localparam int K   = ($clog2(PANEL_SIZE) > RAW_W) ? $clog2(PANEL_SIZE) : RAW_W;
    localparam int CW  = K + 2;
    localparam int SQW = 2 * K + 2;
    localparam int TW  = 2 * K + 4;
    localparam logic signed [CW-1:0] M      = CW'(PANEL_SIZE - 1);
    localparam logic [ORI_W-1:0]     MY_IDX = ORI_W'(IDX);

    function automatic logic [2*CW-1:0] map_pt(
        input logic [RAW_W-1:0] rx,
        input logic [RAW_W-1:0] ry,
        input t_flips           f
    );
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        x = $signed({{(CW-RAW_W){1'b0}}, rx});
        y = $signed({{(CW-RAW_W){1'b0}}, ry});
        unique case (MY_IDX)
            3'd0: begin sx = x;     sy = y;     end
            3'd1: begin sx = y;     sy = M - x; end
            3'd2: begin sx = M - x; sy = M - y; end
            3'd3: begin sx = M - y; sy = x;     end
            3'd4: begin sx = y;     sy = x;     end
            3'd5: begin sx = M - x; sy = y;     end
            3'd6: begin sx = M - y; sy = M - x; end
            default: begin sx = x;  sy = M - y; end
        endcase
        if (f.flip_x) sx = M - sx;
        if (f.flip_y) sy = M - sy;
        return {sx, sy};
    endfunction

    logic signed [CW-1:0]   w_sx_a, w_sy_a, w_sx_b, w_sy_b;
    logic signed [CW-1:0]   w_dx_a, w_dy_a, w_dx_b, w_dy_b;
    logic signed [2*CW-1:0] w_p [4];
    logic [TW-1:0]          w_sum;
    logic                   w_take;
    logic                   w_rdy1, w_rdy2;

    logic                   r1_vld;
    t_taps                  r1_taps;
    logic [ORI_W-1:0]       r1_best;
    logic [TW-1:0]          r1_total;
    logic [SQW-1:0]         r1_sq [4];
    logic                   r2_vld;
    t_taps                  r2_taps;
    logic [ORI_W-1:0]       r2_best;
    logic [TW-1:0]          r2_total;

    always_comb begin
        {w_sx_a, w_sy_a} = map_pt(i_taps.first_raw_x, i_taps.first_raw_y, i_flips);
        {w_sx_b, w_sy_b} = map_pt(i_taps.second_raw_x, i_taps.second_raw_y, i_flips);
        w_dx_a = w_sx_a - $signed({{(CW-GOAL_W){1'b0}}, i_taps.first_goal_x});
        w_dy_a = w_sy_a - $signed({{(CW-GOAL_W){1'b0}}, i_taps.first_goal_y});
        w_dx_b = w_sx_b - $signed({{(CW-GOAL_W){1'b0}}, i_taps.second_goal_x});
        w_dy_b = w_sy_b - $signed({{(CW-GOAL_W){1'b0}}, i_taps.second_goal_y});
        w_p[0] = w_dx_a * w_dx_a;
        w_p[1] = w_dy_a * w_dy_a;
        w_p[2] = w_dx_b * w_dx_b;
        w_p[3] = w_dy_b * w_dy_b;
    end

    assign w_sum  = TW'(r1_sq[0]) + TW'(r1_sq[1]) + TW'(r1_sq[2]) + TW'(r1_sq[3]);
    assign w_take = (IDX == 0) || (w_sum < r1_total);

    assign w_rdy2 = !r2_vld || i_rdy;
    assign w_rdy1 = !r1_vld || w_rdy2;
    assign o_rdy  = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (w_rdy1) r1_vld <= i_vld;
            if (w_rdy2) r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_vld) begin
            r1_taps  <= i_taps;
            r1_best  <= i_best;
            r1_total <= i_total;
            for (int j = 0; j < 4; j++) r1_sq[j] <= w_p[j][SQW-1:0];
        end
        if (w_rdy2 && r1_vld) begin
            r2_taps  <= r1_taps;
            r2_best  <= w_take ? MY_IDX : r1_best;
            r2_total <= w_take ? w_sum : r1_total;
        end
    end

    assign o_vld   = r2_vld;
    assign o_taps  = r2_taps;
    assign o_best  = r2_best;
    assign o_total = r2_total;

endmodule

// ===== rtl/tos_sqrt_cell.sv =====
// One square-root cell: settles one root bit from two radicand bits
// (restoring digit recurrence) and hands the partial result on. Uses tos_pkg.
`timescale 1ns / 1ps

module tos_sqrt_cell import tos_pkg::*; #(
    parameter int RW = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  logic [2*RW-1:0]     i_rad,
    input  logic [RW+1:0]       i_rem,
    input  logic [RW-1:0]       i_root,
    input  logic [ORI_W-1:0]    i_best,
    output logic                o_vld,
    input  logic                i_rdy,
    output logic [2*RW-1:0]     o_rad,
    output logic [RW+1:0]       o_rem,
    output logic [RW-1:0]       o_root,
    output logic [ORI_W-1:0]    o_best
);

    localparam int SW = 2 * RW;

    logic [RW+3:0]      w_tmp, w_trial, w_diff;
    logic               w_ge, w_rdy;
    logic               r_vld;
    logic [SW-1:0]      r_rad;
    logic [RW+1:0]      r_rem;
    logic [RW-1:0]      r_root;
    logic [ORI_W-1:0]   r_best;

    assign w_tmp   = {i_rem, i_rad[SW-1:SW-2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_tmp >= w_trial);
    assign w_diff  = w_tmp - w_trial;
    assign w_rdy   = !r_vld || i_rdy;
    assign o_rdy   = w_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_vld) begin
            r_rad  <= {i_rad[SW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[RW+1:0] : w_tmp[RW+1:0];
            r_root <= {i_root[RW-2:0], w_ge};
            r_best <= i_best;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_best = r_best;

endmodule

// ===== rtl/touch_orientation_solver_top.sv =====
// Top level of the touch orientation solver: mounting cell row, root cell row,
// result register. Depends on tos_pkg, tos_in_if, tos_out_if and both cells.
`timescale 1ns / 1ps

// Takes one two-tap calibration beat per cycle while the output takes results,
// and returns one result beat per input beat, in order. Eight mounting cells
// (two register stages each) score the mountings in turn and keep the least
// total, lowest index on ties; a row of K+3 root cells, one result bit each,
// forms round(sqrt(total/2)), where K = max(clog2(PANEL_SIZE), 10); a result
// register follows. Each stage moves whenever its successor is free, so input
// beats are taken while a result waits on the output. The user must write the
// flips through the config port only while the block is empty; the block
// itself does not enforce this.

module touch_orientation_solver_top import tos_pkg::*; #(
    parameter int PANEL_SIZE = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    tos_in_if.sink            i_tap,
    tos_out_if.source         o_res
);

    localparam int K  = ($clog2(PANEL_SIZE) > RAW_W) ? $clog2(PANEL_SIZE) : RAW_W;
    localparam int TW = 2 * K + 4;
    localparam int RW = K + 3;
    localparam int SW = 2 * RW;

    logic              r_flip_x, r_flip_y;
    t_flips            w_flips;

    logic              w_vld   [0:MOUNT_COUNT];
    logic              w_rdy   [0:MOUNT_COUNT];
    t_taps             w_taps  [0:MOUNT_COUNT];
    logic [ORI_W-1:0]  w_best  [0:MOUNT_COUNT];
    logic [TW-1:0]     w_total [0:MOUNT_COUNT];

    logic              s_vld  [0:RW];
    logic              s_rdy  [0:RW];
    logic [SW-1:0]     s_rad  [0:RW];
    logic [RW+1:0]     s_rem  [0:RW];
    logic [RW-1:0]     s_root [0:RW];
    logic [ORI_W-1:0]  s_best [0:RW];

    logic [RW:0]       w_rnd;
    logic [RW-1:0]     w_half;
    logic              r_out_vld;
    logic [ORI_W-1:0]  r_out_best;
    logic [ERR_W-1:0]  r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_x <= 1'b0;
            r_flip_y <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLIP_X: r_flip_x <= i_cfg_data[0];
                CFG_FLIP_Y: r_flip_y <= i_cfg_data[0];
            endcase
        end
    end

    assign w_flips.flip_x = r_flip_x;
    assign w_flips.flip_y = r_flip_y;

    assign w_vld[0]                = i_tap.valid;
    assign i_tap.ready             = w_rdy[0];
    assign w_taps[0].first_raw_x   = i_tap.first_raw_x;
    assign w_taps[0].first_raw_y   = i_tap.first_raw_y;
    assign w_taps[0].first_goal_x  = i_tap.first_goal_x;
    assign w_taps[0].first_goal_y  = i_tap.first_goal_y;
    assign w_taps[0].second_raw_x  = i_tap.second_raw_x;
    assign w_taps[0].second_raw_y  = i_tap.second_raw_y;
    assign w_taps[0].second_goal_x = i_tap.second_goal_x;
    assign w_taps[0].second_goal_y = i_tap.second_goal_y;
    assign w_best[0]               = '0;
    assign w_total[0]              = '0;

    for (genvar g = 0; g < MOUNT_COUNT; g++) begin : g_mount
        tos_mount_cell #(
            .PANEL_SIZE (PANEL_SIZE),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flips (w_flips),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_taps  (w_taps[g]),
            .i_best  (w_best[g]),
            .i_total (w_total[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_taps  (w_taps[g+1]),
            .o_best  (w_best[g+1]),
            .o_total (w_total[g+1])
        );
    end

    assign s_vld[0]            = w_vld[MOUNT_COUNT];
    assign w_rdy[MOUNT_COUNT]  = s_rdy[0];
    assign s_rad[0]            = SW'({w_total[MOUNT_COUNT], 1'b0});
    assign s_rem[0]            = '0;
    assign s_root[0]           = '0;
    assign s_best[0]           = w_best[MOUNT_COUNT];

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        tos_sqrt_cell #(
            .RW (RW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (s_vld[g]),
            .o_rdy   (s_rdy[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_best  (s_best[g]),
            .o_vld   (s_vld[g+1]),
            .i_rdy   (s_rdy[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_best  (s_best[g+1])
        );
    end

    // round half of the root of 2T, then saturate
    assign w_rnd     = {1'b0, s_root[RW]} + (RW+1)'(1);
    assign w_half    = w_rnd[RW:1];
    assign s_rdy[RW] = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_rdy[RW]) begin
            r_out_vld <= s_vld[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[RW] && s_vld[RW]) begin
            r_out_best <= s_best[RW];
            r_out_err  <= (w_half > RW'(ERR_MAX)) ? ERR_W'(ERR_MAX) : w_half[ERR_W-1:0];
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.best_orientation = r_out_best;
    assign o_res.error_pixels     = r_out_err;

endmodule
